FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, all clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at the same edge.
`define CLPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication that must hold at the following edge.
`define CLPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/clps_pkg.sv
// ---------------------------------------------------------------------------
// clps_pkg
// Types, codes and defaults shared by the positional store and its checker.
// ---------------------------------------------------------------------------
package clps_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int VALUE_BITS_DEF = 32;

	// Port field widths
	localparam int MODE_W   = 2;
	localparam int IOVAL_W  = 32;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [MODE_W-1:0] {
		MD_INS_FRONT = 2'd0,
		MD_INS_BACK  = 2'd1,
		MD_RM_FRONT  = 2'd2,
		MD_RM_POS    = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// What one cell does at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD       = 2'd0,
		CELL_LOAD       = 2'd1,
		CELL_TAKE_LEFT  = 2'd2,
		CELL_TAKE_RIGHT = 2'd3
	} cell_op_t;

endpackage

FILE: hdl/circular_list_positional_store_core.sv
// ---------------------------------------------------------------------------
// circular_list_positional_store_core
// Ordered store of up to DEPTH signed values with positional insert/remove.
// ---------------------------------------------------------------------------
// The store keeps entries in positions 1..count, position 1 at the front, in
// a row of DEPTH cells. Each transfer on the input channel is one operation
// (insert front, insert back, remove front, remove at a 1-based position) and
// produces exactly one transfer on the output channel carrying the status,
// the new count, the front value and the removed value. Every cell decides
// its own next value in the same cycle (hold, load the new value, take the
// left neighbour's or the right neighbour's value), so one operation can be
// accepted on every clock while the input is not stalled; the result is
// registered before it reaches the output channel. The input is stalled
// only while a result sits in the output register and the output side is
// stalling. A full store refuses inserts, an empty store refuses removals,
// and a position outside 1..count is refused without any wrap; refused
// operations leave the store untouched. Entry contents need no clearing
// after reset: only positions below the count are ever read.
// ---------------------------------------------------------------------------
module circular_list_positional_store_core
	import clps_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [MODE_W-1:0]          mode,
	input  logic signed [IOVAL_W-1:0]  value,
	input  logic [POS_W-1:0]           position,
	// output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [COUNT_W-1:0]         entry_count,
	output logic signed [IOVAL_W-1:0]  front_value,
	output logic signed [IOVAL_W-1:0]  removed_value
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IDXW = $clog2(DEPTH);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	// control state
	logic [CW-1:0] count_q;
	logic          out_valid_q;

	// result register
	status_t              status_q;
	logic [CW-1:0]        count_res_q;
	logic [IOVAL_W-1:0]   front_q;
	logic [IOVAL_W-1:0]   removed_q;

	// cell row
	logic [VALUE_BITS-1:0] cell_d [DEPTH];
	logic [VALUE_BITS-1:0] cell_q [DEPTH];
	logic [VALUE_BITS-1:0] left_w [DEPTH];
	logic [VALUE_BITS-1:0] right_w[DEPTH];
	cell_op_t              cell_op[DEPTH];

	mode_t                 md;
	status_t               status_c;
	logic                  take;
	logic                  commit;
	logic                  is_remove;
	logic [CMPW-1:0]       pos_c;
	logic [CMPW-1:0]       cnt_c;
	logic [CMPW-1:0]       pos_m1;
	logic [IDXW-1:0]       rm_idx;
	logic [CW-1:0]         count_next;
	logic [63:0]           val_ext;
	logic [VALUE_BITS-1:0] val_in;
	logic [63:0]           front_ext;
	logic [63:0]           removed_ext;
	logic [CMPW-1:0]       count_out_ext;

	assign md        = mode_t'(mode);
	assign is_remove = (md == MD_RM_FRONT) || (md == MD_RM_POS);

	// Sign-extend the 32-bit input, then fit it to the cell width
	assign val_ext = {{(64 - IOVAL_W){value[IOVAL_W-1]}}, value};
	assign val_in  = val_ext[VALUE_BITS-1:0];

	assign pos_c  = CMPW'(position);
	assign cnt_c  = CMPW'(count_q);
	assign pos_m1 = pos_c - CMPW'(1);

	always_comb begin
		unique case (md)
			MD_INS_FRONT, MD_INS_BACK: begin
				status_c = (count_q == CW'(DEPTH)) ? ST_FULL : ST_OK;
			end
			MD_RM_FRONT: begin
				status_c = (count_q == '0) ? ST_EMPTY : ST_OK;
			end
			default: begin
				if (count_q == '0) begin
					status_c = ST_EMPTY;
				end else if (pos_c == '0 || pos_c > cnt_c) begin
					status_c = ST_RANGE;
				end else begin
					status_c = ST_OK;
				end
			end
		endcase
	end

	// Index of the removed cell, front for a front removal
	assign rm_idx = (md == MD_RM_FRONT) ? '0 : pos_m1[IDXW-1:0];

	// Hold the input while an unread result is stalled at the output
	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;
	assign commit   = take && (status_c == ST_OK);

	always_comb begin
		count_next = count_q;
		if (commit) begin
			count_next = is_remove ? (count_q - CW'(1)) : (count_q + CW'(1));
		end
	end

	// Build the row: neighbour wiring and the per-cell decision
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_left_edge
			assign left_w[i] = val_in;
		end else begin : g_left
			assign left_w[i] = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_right_edge
			assign right_w[i] = cell_q[i];
		end else begin : g_right
			assign right_w[i] = cell_q[i+1];
		end

		always_comb begin
			cell_op[i] = CELL_HOLD;
			if (commit) begin
				unique case (md)
					MD_INS_FRONT: begin
						// shift everything one place back, new value at the front
						cell_op[i] = (i == 0) ? CELL_LOAD : CELL_TAKE_LEFT;
					end
					MD_INS_BACK: begin
						cell_op[i] = (count_q == CW'(i)) ? CELL_LOAD : CELL_HOLD;
					end
					default: begin
						// close the gap: cells at and behind the removed one advance
						if (i < DEPTH - 1 && rm_idx <= IDXW'(i)) begin
							cell_op[i] = CELL_TAKE_RIGHT;
						end
					end
				endcase
			end
		end

		clps_cell #(
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk         (clk),
			.op          (cell_op[i]),
			.in_value    (val_in),
			.left_value  (left_w[i]),
			.right_value (right_w[i]),
			.value_d     (cell_d[i]),
			.value_q     (cell_q[i])
		);
	end

	// Results are reported zero-extended from the cell width
	assign front_ext   = (count_next == '0) ? 64'd0 : 64'(cell_d[0]);
	assign removed_ext = (commit && is_remove) ? 64'(cell_q[rm_idx]) : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: load on every accepted transfer
	always_ff @(posedge clk) begin
		if (take) begin
			status_q    <= status_c;
			count_res_q <= count_next;
			front_q     <= front_ext[IOVAL_W-1:0];
			removed_q   <= removed_ext[IOVAL_W-1:0];
		end
	end

	assign count_out_ext = CMPW'(count_res_q);

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign entry_count   = count_out_ext[COUNT_W-1:0];
	assign front_value   = front_q;
	assign removed_value = removed_q;

endmodule

FILE: hdl/clps_cell.sv
// ---------------------------------------------------------------------------
// clps_cell
// One row position: holds a value, loads, or takes a neighbour's value.
// ---------------------------------------------------------------------------
module clps_cell
	import clps_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  cell_op_t              op,
	input  logic [VALUE_BITS-1:0] in_value,
	input  logic [VALUE_BITS-1:0] left_value,
	input  logic [VALUE_BITS-1:0] right_value,
	output logic [VALUE_BITS-1:0] value_d,
	output logic [VALUE_BITS-1:0] value_q
);

	always_comb begin
		unique case (op)
			CELL_LOAD:       value_d = in_value;
			CELL_TAKE_LEFT:  value_d = left_value;
			CELL_TAKE_RIGHT: value_d = right_value;
			default:         value_d = value_q;
		endcase
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

FILE: hdl/clps_checker.sv
// ---------------------------------------------------------------------------
// clps_checker
// Port-level checks on the positional store, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module clps_checker
	import clps_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [STATUS_W-1:0]       status,
	input logic [COUNT_W-1:0]        entry_count,
	input logic signed [IOVAL_W-1:0] front_value,
	input logic signed [IOVAL_W-1:0] removed_value
);

	localparam int                 CW       = $clog2(DEPTH + 1);
	localparam int                 FW       = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [FW-1:0]      DEPTH_FW = FW'(DEPTH);
	localparam logic [COUNT_W-1:0] FULL_CNT = DEPTH_FW[COUNT_W-1:0];

	// a result held at the output does not move
	`CLPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		$stable(status) && $stable(entry_count) && $stable(front_value)
		&& $stable(removed_value), "result changed while stalled")

	// input is only ever held back by a waiting result
	`CLPS_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall,
		"input stalled with no result waiting")

	// a refused insert reports a full store
	`CLPS_ASSERT_IMP(a_full_count, out_valid && status == ST_FULL,
		entry_count == FULL_CNT && removed_value == '0, "full status with wrong count")

	// a refused removal on an empty store reports nothing
	`CLPS_ASSERT_IMP(a_empty_zero, out_valid && status == ST_EMPTY,
		entry_count == '0 && front_value == '0 && removed_value == '0,
		"empty status with non-zero fields")

	// a refused position removes nothing
	`CLPS_ASSERT_IMP(a_range_zero, out_valid && status == ST_RANGE,
		removed_value == '0 && entry_count != '0, "range status with a removed value")

endmodule

bind circular_list_positional_store_core clps_checker #(
	.DEPTH (DEPTH)
) u_clps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.entry_count   (entry_count),
	.front_value   (front_value),
	.removed_value (removed_value)
);
